FILE: rtl/static_linked_list_engine_defines.svh
// Assertion macros shared by the checker of the static linked list engine.
// The macros expect signals named clock and reset in the scope of their use.
`ifndef STATIC_LINKED_LIST_ENGINE_DEFINES_SVH
`define STATIC_LINKED_LIST_ENGINE_DEFINES_SVH

// Property that must hold in the same cycle as its antecedent.
`define SLL_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("static linked list engine: check failed");

// Property that must hold in the cycle after its antecedent.
`define SLL_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("static linked list engine: check failed");

`endif

FILE: rtl/sll_pkg.sv
// Package of the static linked list engine: field widths, codes and defaults.
// Used by the interfaces, the top level and the checker.
`default_nettype none

package sll_pkg;

   // Fixed widths of the word fields.
   localparam int DATA_W   = 32;
   localparam int SLOT_W   = 4;
   localparam int COUNT_W  = 4;

   // Default number of slots, including the two chain heads.
   localparam int LIST_LEN_DEF = 16;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_INSERTED  = 2'd0,
      ST_FULL      = 2'd1,
      ST_REMOVED   = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

endpackage

`default_nettype wire

FILE: rtl/sll_if.sv
// Valid/ready channel interfaces of the static linked list engine.
// Depends on sll_pkg for the payload types and widths.
`default_nettype none

// Request channel: one operation word.
interface sll_req_if;
   import sll_pkg::*;

   logic                     valid;
   logic                     ready;
   op_type                   op;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, output op, output value, input ready);
   modport sink   (input valid, input op, input value, output ready);
endinterface

// Response channel: one result word.
interface sll_rsp_if;
   import sll_pkg::*;

   logic                     valid;
   logic                     ready;
   status_type               status;
   logic [SLOT_W-1:0]        slot_index;
   logic signed [DATA_W-1:0] removed_value;
   logic [COUNT_W-1:0]       item_count;

   modport source (output valid, output status, output slot_index, output removed_value,
                   output item_count, input ready);
   modport sink   (input valid, input status, input slot_index, input removed_value,
                   input item_count, output ready);
endinterface

`default_nettype wire

FILE: rtl/sll_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module sll_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

FILE: rtl/static_linked_list_engine.sv
// Top level of the static linked list engine: sequencer, chain heads and result register.
// Depends on sll_pkg, the channel interfaces in sll_if and the RAM in sll_ram.
//
// The engine keeps a cursor list of LIST_LEN slots: the free chain and the used chain heads
// sit in registers, and the links and values of slots 1 to LIST_LEN-2 sit in two RAMs. An
// insert takes the first free slot, puts it at the head of the used chain and reports the
// slot, or reports full. A remove searches the used chain from the newest entry for the
// first slot holding the value, unlinks it and returns it to the free chain, or reports not
// found. Each request word gives exactly one response word. After reset the engine builds
// the free chain in the link RAM and only then raises req ready. A remove that walks the
// used chain visits one slot per cycle, since the link RAM has a single read port. The
// engine works on one request at a time; it takes the next request while an earlier
// response still waits.
`default_nettype none

module static_linked_list_engine #(
   parameter int LIST_LEN = sll_pkg::LIST_LEN_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   sll_req_if.sink   req_ch,
   sll_rsp_if.source rsp_ch
);
   import sll_pkg::*;

   localparam int IDX_W = $clog2(LIST_LEN);
   localparam int CNT_W = $clog2(LIST_LEN - 1);
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(LIST_LEN - 2);
   localparam logic [IDX_W-1:0] TOP_IDX   = IDX_W'(LIST_LEN - 1);

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_INSERT,
      S_WALK,
      S_UNLINK,
      S_DONE
   } state_type;

   state_type                state_ff, state_in;
   logic [IDX_W-1:0]         init_ff, init_in;
   logic [IDX_W-1:0]         free_head_ff, free_head_in;
   logic [IDX_W-1:0]         used_head_ff, used_head_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [IDX_W-1:0]         cur_ff, cur_in;
   logic [IDX_W-1:0]         prev_ff, prev_in;
   logic                     prev_head_ff, prev_head_in;
   logic signed [DATA_W-1:0] val_ff, val_in;
   status_type               res_status_ff, res_status_in;
   logic [IDX_W-1:0]         res_slot_ff, res_slot_in;
   logic signed [DATA_W-1:0] res_value_ff, res_value_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]        rsp_slot_ff, rsp_slot_in;
   logic signed [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic [COUNT_W-1:0]       rsp_count_ff, rsp_count_in;

   logic                     link_we;
   logic [IDX_W-1:0]         link_waddr;
   logic [IDX_W-1:0]         link_wdata;
   logic [IDX_W-1:0]         link_rdata;
   logic                     vmem_we;
   logic [IDX_W-1:0]         vmem_waddr;
   logic [DATA_W-1:0]        vmem_wdata;
   logic [DATA_W-1:0]        vmem_rdata;
   logic [IDX_W-1:0]         rd_addr;
   logic                     req_fire;
   logic                     out_free;

   // Link and value storage of the data slots.
   sll_ram #(.WIDTH(IDX_W), .DEPTH(LIST_LEN)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_addr (rd_addr),
      .rd_data (link_rdata)
   );

   sll_ram #(.WIDTH(DATA_W), .DEPTH(LIST_LEN)) u_value_ram (
      .clock   (clock),
      .wr_en   (vmem_we),
      .wr_addr (vmem_waddr),
      .wr_data (vmem_wdata),
      .rd_addr (rd_addr),
      .rd_data (vmem_rdata)
   );

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_fire     = req_ch.valid && (state_ff == S_IDLE);
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.status        = rsp_status_ff;
   assign rsp_ch.slot_index    = rsp_slot_ff;
   assign rsp_ch.removed_value = rsp_value_ff;
   assign rsp_ch.item_count    = rsp_count_ff;

   // Sequencer: next state, chain updates and RAM controls.
   always_comb begin
      state_in      = state_ff;
      init_in       = init_ff;
      free_head_in  = free_head_ff;
      used_head_in  = used_head_ff;
      count_in      = count_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      prev_head_in  = prev_head_ff;
      val_in        = val_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_value_in  = res_value_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_count_in  = rsp_count_ff;
      link_we       = 1'b0;
      link_waddr    = cur_ff;
      link_wdata    = free_head_ff;
      vmem_we       = 1'b0;
      vmem_waddr    = cur_ff;
      vmem_wdata    = '0;
      rd_addr       = cur_ff;

      unique case (state_ff)
         // Build the free chain one link per cycle after reset.
         S_INIT: begin
            link_we    = 1'b1;
            link_waddr = init_ff;
            link_wdata = (init_ff == '0 || init_ff >= LAST_SLOT) ? '0
                                                                  : init_ff + IDX_W'(1);
            if (init_ff == TOP_IDX) begin
               state_in = S_IDLE;
            end else begin
               init_in = init_ff + IDX_W'(1);
            end
         end

         // Take a request and start the first link read.
         S_IDLE: begin
            if (req_fire) begin
               val_in        = req_ch.value;
               res_slot_in   = '0;
               res_value_in  = '0;
               if (req_ch.op == OP_INSERT) begin
                  if (free_head_ff == '0) begin
                     res_status_in = ST_FULL;
                     state_in      = S_DONE;
                  end else begin
                     rd_addr  = free_head_ff;
                     cur_in   = free_head_ff;
                     state_in = S_INSERT;
                  end
               end else begin
                  if (used_head_ff == '0) begin
                     res_status_in = ST_NOT_FOUND;
                     state_in      = S_DONE;
                  end else begin
                     rd_addr      = used_head_ff;
                     cur_in       = used_head_ff;
                     prev_head_in = 1'b1;
                     state_in     = S_WALK;
                  end
               end
            end
         end

         // Pop the free slot and push it on the used chain.
         S_INSERT: begin
            free_head_in  = link_rdata;
            link_we       = 1'b1;
            link_waddr    = cur_ff;
            link_wdata    = used_head_ff;
            vmem_we       = 1'b1;
            vmem_waddr    = cur_ff;
            vmem_wdata    = val_ff;
            used_head_in  = cur_ff;
            count_in      = count_ff + CNT_W'(1);
            res_status_in = ST_INSERTED;
            res_slot_in   = cur_ff;
            state_in      = S_DONE;
         end

         // Compare one used slot per cycle and follow its link.
         S_WALK: begin
            if (vmem_rdata == val_ff) begin
               if (prev_head_ff) begin
                  used_head_in = link_rdata;
               end else begin
                  link_we    = 1'b1;
                  link_waddr = prev_ff;
                  link_wdata = link_rdata;
               end
               state_in = S_UNLINK;
            end else if (link_rdata == '0) begin
               res_status_in = ST_NOT_FOUND;
               state_in      = S_DONE;
            end else begin
               rd_addr      = link_rdata;
               prev_in      = cur_ff;
               prev_head_in = 1'b0;
               cur_in       = link_rdata;
            end
         end

         // Return the matched slot to the free chain.
         S_UNLINK: begin
            link_we       = 1'b1;
            link_waddr    = cur_ff;
            link_wdata    = free_head_ff;
            vmem_we       = 1'b1;
            vmem_waddr    = cur_ff;
            vmem_wdata    = '0;
            free_head_in  = cur_ff;
            count_in      = count_ff - CNT_W'(1);
            res_status_in = ST_REMOVED;
            res_slot_in   = cur_ff;
            res_value_in  = val_ff;
            state_in      = S_DONE;
         end

         // Hand the result to the response register once it is free.
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = SLOT_W'(res_slot_ff);
               rsp_value_in  = res_value_ff;
               rsp_count_in  = COUNT_W'(count_ff);
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   // State, chain heads and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         init_ff      <= '0;
         free_head_ff <= IDX_W'(1);
         used_head_ff <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         free_head_ff <= free_head_in;
         used_head_ff <= used_head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      prev_head_ff  <= prev_head_in;
      val_ff        <= val_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_value_ff  <= res_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
   end

endmodule

`default_nettype wire

FILE: rtl/sll_checker.sv
// Port checker of the static linked list engine and its bind to the top level.
// Depends on sll_pkg and the macros in static_linked_list_engine_defines.svh.
`include "static_linked_list_engine_defines.svh"
`default_nettype none

module sll_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_valid,
   input wire logic                             req_ready,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_ready,
   input wire logic [1:0]                       rsp_status,
   input wire logic [sll_pkg::SLOT_W-1:0]       rsp_slot_index,
   input wire logic signed [sll_pkg::DATA_W-1:0] rsp_removed_value,
   input wire logic [sll_pkg::COUNT_W-1:0]      rsp_item_count
);
   import sll_pkg::*;

   // The engine works on one request at a time, so it is busy right after taking one.
   `SLL_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)

   // Full and not-found results carry neither a slot nor a value.
   `SLL_ASSERT_NOW(a_empty_result,
      rsp_valid && (rsp_status == ST_FULL || rsp_status == ST_NOT_FOUND),
      rsp_slot_index == '0 && rsp_removed_value == '0)

   // An insert never returns a value.
   `SLL_ASSERT_NOW(a_insert_result, rsp_valid && rsp_status == ST_INSERTED, rsp_removed_value == '0)

   // A stalled response word stays in place.
   `SLL_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_status) && $stable(rsp_slot_index) &&
      $stable(rsp_removed_value) && $stable(rsp_item_count))

endmodule

bind static_linked_list_engine sll_checker u_sll_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_status        (rsp_ch.status),
   .rsp_slot_index    (rsp_ch.slot_index),
   .rsp_removed_value (rsp_ch.removed_value),
   .rsp_item_count    (rsp_ch.item_count)
);

`default_nettype wire
